// File: hdl/telnet_option_negotiator_macros.svh
// ----------------------------------------------------------------------------
// Telnet option negotiator assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TELNET_OPTION_NEGOTIATOR_MACROS_SVH
`define TELNET_OPTION_NEGOTIATOR_MACROS_SVH

`ifndef SYNTHESIS
`define TON_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TON_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TON_ASSERT(lbl, clk, rst_n, prop, msg)
`define TON_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/tono_pkg.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator package
// Protocol codes, reply descriptor type and the terminal type string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tono_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;

  localparam logic [7:0] TT_IS   = 8'd0;
  localparam logic [7:0] TT_SEND = 8'd1;

  localparam logic [1:0] ACT_NET    = 2'd0;
  localparam logic [1:0] ACT_TERM   = 2'd1;
  localparam logic [1:0] ACT_RESIZE = 2'd2;
  localparam logic [1:0] ACT_START  = 2'd3;

  localparam int          STEP_W     = 5;
  localparam logic [4:0]  TTYPE_LAST = 5'd19;
  localparam logic [4:0]  CMD_LAST   = 5'd2;
  localparam logic [4:0]  NAWS_OFS   = 5'd3;
  localparam logic [3:0]  NAWS_LAST  = 4'd8;

  // Reply kinds queued between decoder and byte sequencer
  typedef enum logic [2:0] {
    K_TERM  = 3'd0,  // one byte to the terminal
    K_ECHO  = 3'd1,  // terminal byte to network, IAC doubled
    K_CMD   = 3'd2,  // IAC cmd opt
    K_WNAWS = 3'd3,  // IAC WILL NAWS followed by window size
    K_NAWS  = 3'd4,  // window size subnegotiation
    K_TTYPE = 3'd5   // terminal type reply
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  cmd;
    logic [15:0] cols;
    logic [15:0] rows;
    logic        naws;
    logic        binary;
    logic        sga;
  } desc_t;

  function automatic logic [7:0] ttype_byte(input logic [STEP_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = B_IAC;
      5'd1:    b = B_SB;
      5'd2:    b = OPT_TTYPE;
      5'd3:    b = TT_IS;
      5'd4:    b = 8'h78;
      5'd5:    b = 8'h74;
      5'd6:    b = 8'h65;
      5'd7:    b = 8'h72;
      5'd8:    b = 8'h6d;
      5'd9:    b = 8'h2d;
      5'd10:   b = 8'h32;
      5'd11:   b = 8'h35;
      5'd12:   b = 8'h36;
      5'd13:   b = 8'h63;
      5'd14:   b = 8'h6f;
      5'd15:   b = 8'h6c;
      5'd16:   b = 8'h6f;
      5'd17:   b = 8'h72;
      5'd18:   b = B_IAC;
      default: b = B_SE;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/tono_front.sv
// ----------------------------------------------------------------------------
// Telnet receive decoder
// Runs the protocol state per beat and queues at most one reply descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tono_front import tono_pkg::*; #(
  parameter int SUB_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [15:0] new_cols,
  input  logic [15:0] new_rows,
  output logic        q_push,
  output desc_t       q_desc
);

  localparam int CW = $clog2(SUB_LIMIT + 1);

  typedef enum logic [7:0] {
    PH_DATA   = 8'b0000_0001,
    PH_IAC    = 8'b0000_0010,
    PH_WILL   = 8'b0000_0100,
    PH_WONT   = 8'b0000_1000,
    PH_DO     = 8'b0001_0000,
    PH_DONT   = 8'b0010_0000,
    PH_SB     = 8'b0100_0000,
    PH_SB_IAC = 8'b1000_0000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [CW-1:0] sub_count_r, sub_count_nxt;
  logic [7:0]  sub_option_r, sub_option_nxt;
  logic [7:0]  sub_second_r, sub_second_nxt;
  logic        naws_r, naws_nxt;
  logic        binary_r, binary_nxt;
  logic        sga_r, sga_nxt;
  logic [15:0] cols_r, cols_nxt;
  logic [15:0] rows_r, rows_nxt;
  logic        emit;
  kind_t       kind;
  logic [7:0]  cmd;
  logic        store_en;
  logic [7:0]  store_byte;
  logic        ttype_hit;

  assign ttype_hit = (sub_count_r >= CW'(2)) && (sub_option_r == OPT_TTYPE) &&
                     (sub_second_r == TT_SEND);

  always_comb begin
    phase_nxt      = phase_r;
    sub_count_nxt  = sub_count_r;
    sub_option_nxt = sub_option_r;
    sub_second_nxt = sub_second_r;
    naws_nxt       = naws_r;
    binary_nxt     = binary_r;
    sga_nxt        = sga_r;
    cols_nxt       = cols_r;
    rows_nxt       = rows_r;
    emit           = 1'b0;
    kind           = K_TERM;
    cmd            = B_IAC;
    store_en       = 1'b0;
    store_byte     = data_byte;
    unique case (action)
      ACT_NET: begin
        unique case (phase_r)
          PH_DATA: begin
            if (data_byte == B_IAC) begin
              phase_nxt = PH_IAC;
            end else begin
              emit = 1'b1;
            end
          end
          PH_IAC: begin
            phase_nxt = PH_DATA;
            case (data_byte)
              B_IAC:   emit = 1'b1;
              B_WILL:  phase_nxt = PH_WILL;
              B_WONT:  phase_nxt = PH_WONT;
              B_DO:    phase_nxt = PH_DO;
              B_DONT:  phase_nxt = PH_DONT;
              B_SB: begin
                phase_nxt     = PH_SB;
                sub_count_nxt = '0;
              end
              default: phase_nxt = PH_DATA;
            endcase
          end
          PH_WILL: begin
            phase_nxt = PH_DATA;
            emit      = 1'b1;
            kind      = K_CMD;
            cmd       = B_DO;
            case (data_byte)
              OPT_ECHO:   cmd = B_DO;
              OPT_SGA:    sga_nxt = 1'b1;
              OPT_BINARY: binary_nxt = 1'b1;
              default:    cmd = B_DONT;
            endcase
          end
          PH_WONT: phase_nxt = PH_DATA;
          PH_DO: begin
            phase_nxt = PH_DATA;
            emit      = 1'b1;
            kind      = K_CMD;
            cmd       = B_WILL;
            case (data_byte)
              OPT_NAWS: begin
                kind     = K_WNAWS;
                naws_nxt = 1'b1;
              end
              OPT_TTYPE:  cmd = B_WILL;
              OPT_BINARY: binary_nxt = 1'b1;
              OPT_SGA:    sga_nxt = 1'b1;
              default:    cmd = B_WONT;
            endcase
          end
          PH_DONT: begin
            phase_nxt = PH_DATA;
            emit      = 1'b1;
            kind      = K_CMD;
            cmd       = B_WONT;
          end
          PH_SB: begin
            if (data_byte == B_IAC) begin
              phase_nxt = PH_SB_IAC;
            end else begin
              store_en = 1'b1;
            end
          end
          PH_SB_IAC: begin
            if (data_byte == B_SE) begin
              phase_nxt = PH_DATA;
              emit      = ttype_hit;
              kind      = K_TTYPE;
            end else if (data_byte == B_IAC) begin
              phase_nxt = PH_SB;
              store_en  = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          default: phase_nxt = PH_DATA;
        endcase
      end
      ACT_TERM: begin
        emit = 1'b1;
        kind = K_ECHO;
      end
      ACT_RESIZE: begin
        cols_nxt = new_cols;
        rows_nxt = new_rows;
        emit     = naws_r;
        kind     = K_NAWS;
      end
      default: begin
        emit = 1'b1;
        kind = K_CMD;
        cmd  = B_WILL;
      end
    endcase

    if (store_en && (sub_count_r < CW'(SUB_LIMIT))) begin
      if (sub_count_r == '0) begin
        sub_option_nxt = store_byte;
      end
      if (sub_count_r == CW'(1)) begin
        sub_second_nxt = store_byte;
      end
      sub_count_nxt = sub_count_r + CW'(1);
    end
  end

  always_comb begin
    q_desc.kind   = kind;
    q_desc.data   = (action == ACT_START) ? OPT_NAWS : data_byte;
    q_desc.cmd    = cmd;
    q_desc.cols   = cols_nxt;
    q_desc.rows   = rows_nxt;
    q_desc.naws   = naws_nxt;
    q_desc.binary = binary_nxt;
    q_desc.sga    = sga_nxt;
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      sub_count_r <= '0;
      naws_r      <= 1'b0;
      binary_r    <= 1'b0;
      sga_r       <= 1'b0;
      cols_r      <= 16'd80;
      rows_r      <= 16'd24;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      sub_count_r <= sub_count_nxt;
      naws_r      <= naws_nxt;
      binary_r    <= binary_nxt;
      sga_r       <= sga_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sub_option_r <= sub_option_nxt;
      sub_second_r <= sub_second_nxt;
    end
  end

endmodule

// File: hdl/tono_fifo.sv
// ----------------------------------------------------------------------------
// Reply descriptor queue
// Short FIFO between the decoder and the byte sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tono_fifo import tono_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t wdata,
  output logic  full,
  input  logic  pop,
  output desc_t rdata,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hdl/tono_back.sv
// ----------------------------------------------------------------------------
// Reply byte sequencer
// Expands one queued descriptor into result beats, one byte per cycle while out_pop is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "telnet_option_negotiator_macros.svh"

module tono_back import tono_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  desc_t       q_desc,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_dest,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_naws_on,
  output logic        out_binary_on,
  output logic        out_sga_on
);

  logic              cur_valid_r, cur_valid_nxt;
  desc_t             cur_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              dup_r, dup_nxt;
  logic [3:0]        ns;
  logic [7:0]        naws_b;
  logic              naws_val;
  logic              is_val;
  logic              last_raw;
  logic              hold;
  logic              fire;
  logic              load;

  assign ns = (cur_r.kind == K_WNAWS) ? 4'(step_r - NAWS_OFS) : step_r[3:0];

  always_comb begin
    naws_val = 1'b0;
    case (ns)
      4'd0:    naws_b = B_IAC;
      4'd1:    naws_b = B_SB;
      4'd2:    naws_b = OPT_NAWS;
      4'd3: begin
        naws_b   = cur_r.cols[15:8];
        naws_val = 1'b1;
      end
      4'd4: begin
        naws_b   = cur_r.cols[7:0];
        naws_val = 1'b1;
      end
      4'd5: begin
        naws_b   = cur_r.rows[15:8];
        naws_val = 1'b1;
      end
      4'd6: begin
        naws_b   = cur_r.rows[7:0];
        naws_val = 1'b1;
      end
      4'd7:    naws_b = B_IAC;
      default: naws_b = B_SE;
    endcase
  end

  always_comb begin
    out_dest = 1'b1;
    out_byte = cur_r.data;
    is_val   = 1'b0;
    last_raw = 1'b0;
    unique case (cur_r.kind)
      K_TERM: begin
        out_dest = 1'b0;
        last_raw = 1'b1;
      end
      K_ECHO: begin
        is_val   = 1'b1;
        last_raw = 1'b1;
      end
      K_CMD: begin
        out_byte = (step_r == '0) ? B_IAC : (step_r == STEP_W'(1)) ? cur_r.cmd : cur_r.data;
        last_raw = (step_r == CMD_LAST);
      end
      K_WNAWS: begin
        if (step_r < NAWS_OFS) begin
          out_byte = (step_r == '0) ? B_IAC : (step_r == STEP_W'(1)) ? cur_r.cmd : cur_r.data;
        end else begin
          out_byte = naws_b;
          is_val   = naws_val;
          last_raw = (ns == NAWS_LAST);
        end
      end
      K_NAWS: begin
        out_byte = naws_b;
        is_val   = naws_val;
        last_raw = (ns == NAWS_LAST);
      end
      default: begin
        out_byte = ttype_byte(step_r);
        last_raw = (step_r == TTYPE_LAST);
      end
    endcase
  end

  // A value byte equal to IAC goes out twice
  assign hold     = is_val && (out_byte == B_IAC) && !dup_r;
  assign out_last = last_raw && !hold;

  assign out_empty     = !cur_valid_r;
  assign out_naws_on   = cur_r.naws;
  assign out_binary_on = cur_r.binary;
  assign out_sga_on    = cur_r.sga;

  assign fire  = cur_valid_r && out_pop;
  assign load  = !cur_valid_r || (fire && out_last);
  assign q_pop = load && !q_empty;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    dup_nxt       = dup_r;
    if (load) begin
      cur_valid_nxt = !q_empty;
      step_nxt      = '0;
      dup_nxt       = 1'b0;
    end else if (fire) begin
      if (hold) begin
        dup_nxt = 1'b1;
      end else begin
        step_nxt = step_r + STEP_W'(1);
        dup_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      dup_r       <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      dup_r       <= dup_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_desc;
    end
  end

  `TON_ASSERT(a_ttype_step, clk, rst_n, (cur_valid_r && cur_r.kind == K_TTYPE) |-> (step_r <= TTYPE_LAST), "ttype step overrun")
  `TON_ASSERT(a_naws_step, clk, rst_n, (cur_valid_r && cur_r.kind == K_NAWS) |-> (step_r <= STEP_W'(NAWS_LAST)), "naws step overrun")
  `TON_ASSERT(a_dup_valid, clk, rst_n, dup_r |-> cur_valid_r, "doubling with no reply in progress")
  `TON_ASSERT(a_mid_reply, clk, rst_n, (fire && !out_last) |=> (cur_valid_r && $stable(cur_r.kind)), "reply cut short")

endmodule

// File: hdl/telnet_option_negotiator.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator
// Path: input beat, reply queue, sequencer reply register, out_ ports.
// Throughput: one input beat per cycle while in_full is low; a beat with
// many results holds the sequencer, up to QUEUE_DEPTH replies buffered.
// Reset: synchronous, active low; data phase, flags clear, 80 x 24 window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module telnet_option_negotiator import tono_pkg::*; #(
  parameter int SUB_LIMIT   = 256,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_new_cols,
  input  logic [15:0] in_new_rows,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_dest,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_naws_on,
  output logic        out_binary_on,
  output logic        out_sga_on
);

  logic  accept;
  logic  q_push;
  desc_t q_wdata;
  logic  q_full;
  logic  q_pop;
  desc_t q_rdata;
  logic  q_empty;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  tono_front #(
    .SUB_LIMIT (SUB_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .data_byte (in_data_byte),
    .new_cols  (in_new_cols),
    .new_rows  (in_new_rows),
    .q_push    (q_push),
    .q_desc    (q_wdata)
  );

  tono_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tono_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_desc        (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_dest      (out_dest),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_naws_on   (out_naws_on),
    .out_binary_on (out_binary_on),
    .out_sga_on    (out_sga_on)
  );

endmodule
